@@ rtl/core/lzwd_pkg.sv @@
// lzwd_pkg: shared constants and controller/datapath interface types
// for the .Z stream decoder core; no dependencies

package lzwd_pkg;

   localparam logic [1:0] CMD_FEED = 2'd0;
   localparam logic [1:0] CMD_END  = 2'd1;
   localparam logic [1:0] CMD_PULL = 2'd2;
   localparam logic [1:0] CMD_NOP  = 2'd3;

   localparam logic [3:0] ST_ACCEPT   = 4'd0;
   localparam logic [3:0] ST_BYTE     = 4'd1;
   localparam logic [3:0] ST_BUSY     = 4'd7;
   localparam logic [3:0] ST_EMPTY    = 4'd8;

   localparam logic [2:0] PH_FLAGS    = 3'd0;
   localparam logic [2:0] PH_FIRST    = 3'd1;
   localparam logic [2:0] PH_CODES    = 3'd2;
   localparam logic [2:0] PH_DONE     = 3'd3;
   localparam logic [2:0] PH_TRUNC    = 3'd4;
   localparam logic [2:0] PH_BADFLAGS = 3'd5;
   localparam logic [2:0] PH_BADWIDTH = 3'd6;
   localparam logic [2:0] PH_BADCODE  = 3'd7;

   localparam logic [15:0] CLEAR_CODE = 16'd256;

   // controller to datapath
   typedef struct packed {
      logic       take;      // register request fields
      logic       feed;      // run feed on captured byte
      logic       finish;    // run end of input
      logic       pull;      // pop one byte
      logic       walk;      // one chain step
      logic       push_head; // push head byte and update table
   } lzwd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       code_ready; // feed produced a code needing a walk
      logic       walk_done;  // chain reached a literal
   } lzwd_stat_type;

endpackage

@@ rtl/core/lzw_compress_stream_decoder_core.sv @@
// lzw_compress_stream_decoder_core: top level of the .Z LZW decoder
// depends on lzwd_pkg, lzwd_ctrl, lzwd_datapath
//
// channel  dir  ports
// req      in   req_valid req_ready req_cmd req_in_byte
// rsp      out  rsp_valid rsp_ready rsp_out_byte rsp_status rsp_more_pending
//
// one request at a time: pull and end pass exec and out, feed exec, check
// and out; a feed that decodes a code adds a walk, wait, settle round per
// string byte above the literal (dictionary read latency sets the chain
// step). synchronous reset returns to flags phase. result held until rsp_ready.

module lzw_compress_stream_decoder_core #(
   parameter int MAX_CODE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [3:0] rsp_status,
   output logic       rsp_more_pending
);
   import lzwd_pkg::*;

   lzwd_cmd_type  ctl;
   lzwd_stat_type stat;

   lzwd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .ctl(ctl), .stat(stat)
   );

   lzwd_datapath #(.MaxBits(MAX_CODE_BITS)) u_dp (
      .clock(clock), .reset(reset), .byte_i(req_in_byte),
      .ctl(ctl), .stat(stat), .out_byte_o(rsp_out_byte),
      .status_o(rsp_status), .more_o(rsp_more_pending)
   );
endmodule

@@ rtl/core/lzwd_datapath.sv @@
// lzwd_datapath: bit unpacker, dictionary, reverse stack and result register
// depends on lzwd_pkg

module lzwd_datapath #(
   parameter int MaxBits = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            byte_i,
   input  lzwd_pkg::lzwd_cmd_type  ctl,
   output lzwd_pkg::lzwd_stat_type stat,
   output logic [7:0]            out_byte_o,
   output logic [3:0]            status_o,
   output logic                  more_o
);
   import lzwd_pkg::*;

   localparam int Depth = 1 << MaxBits;

   logic [MaxBits-1:0] prefix_mem [Depth];
   logic [7:0]         suffix_mem [Depth];
   logic [7:0]         stack_mem  [Depth];

   logic [7:0]  byte_ff;
   logic [MaxBits:0] count_ff, count_in;
   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  width_ff, width_in, limit_ff, limit_in;
   logic        block_ff, block_in;
   logic [15:0] last_ff, last_in, prev_ff, prev_in, code_ff, code_in, cur_ff, cur_in;
   logic [7:0]  first_ff, first_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  bits_ff, bits_in, group_ff, group_in, skip_ff, skip_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic [3:0]  ostat_ff, ostat_in;
   logic        ready_ff, ready_in, done_ff, done_in;

   logic        push_en;
   logic [7:0]  push_val;
   logic        tab_we;
   logic [MaxBits-1:0] tab_wa;
   logic [MaxBits-1:0] cur_idx;
   logic [MaxBits-1:0] pop_idx;
   logic [7:0]  pop_byte_ff;

   logic [23:0] merged;
   logic [5:0]  sum_bits;
   logic [15:0] mask, fcode;
   logic [15:0] last_p1;

   assign cur_idx = cur_ff[MaxBits-1:0];
   assign pop_idx = count_ff[MaxBits-1:0] - 1'b1;
   assign mask    = 16'((17'd1 << width_ff) - 17'd1);
   assign last_p1 = last_ff + 16'd1;
   assign merged  = buf_ff | 24'(32'(byte_ff) << bits_ff);
   assign sum_bits = 6'(bits_ff) + 6'd8;
   assign fcode   = 16'(merged & 24'(mask));

   always_ff @(posedge clock) begin
      if (push_en)
         stack_mem[count_ff[MaxBits-1:0]] <= push_val;
      if (tab_we) begin
         prefix_mem[tab_wa] <= prev_ff[MaxBits-1:0];
         suffix_mem[tab_wa] <= first_in;
      end
      if (ctl.pull)
         pop_byte_ff <= stack_mem[pop_idx];
   end

   logic [MaxBits-1:0] pre_rd_ff;
   logic [7:0]         suf_rd_ff;
   always_ff @(posedge clock) begin
      pre_rd_ff <= prefix_mem[cur_idx];
      suf_rd_ff <= suffix_mem[cur_idx];
   end

   always_comb begin
      count_in = count_ff; phase_in = phase_ff; width_in = width_ff;
      limit_in = limit_ff; block_in = block_ff; last_in = last_ff;
      prev_in = prev_ff; code_in = code_ff; cur_in = cur_ff;
      first_in = first_ff; buf_in = buf_ff; bits_in = bits_ff;
      group_in = group_ff; skip_in = skip_ff;
      obyte_in = obyte_ff; ostat_in = ostat_ff;
      ready_in = 1'b0; done_in = 1'b0;
      push_en = 1'b0; push_val = 8'd0; tab_we = 1'b0;
      tab_wa = last_p1[MaxBits-1:0];
      if (ctl.feed) begin
         obyte_in = 8'd0; ostat_in = ST_ACCEPT;
         if (phase_ff >= PH_DONE) ostat_in = 4'(phase_ff) - 4'd1;
         else if (count_ff != '0) ostat_in = ST_BUSY;
         else if (phase_ff == PH_FLAGS) begin
            if ((byte_ff & 8'h60) != 8'd0) begin
               phase_in = PH_BADFLAGS; ostat_in = 4'(PH_BADFLAGS) - 4'd1;
            end else if (byte_ff[4:0] < 5'd9 || byte_ff[4:0] > 5'd16 ||
                         32'(byte_ff[4:0]) > MaxBits) begin
               phase_in = PH_BADWIDTH; ostat_in = 4'(PH_BADWIDTH) - 4'd1;
            end else begin
               limit_in = (byte_ff[4:0] == 5'd9) ? 5'd10 : byte_ff[4:0];
               block_in = byte_ff[7];
               width_in = 5'd9;
               last_in  = byte_ff[7] ? 16'd256 : 16'd255;
               phase_in = PH_FIRST;
            end
         end else if (skip_ff != 5'd0) skip_in = skip_ff - 5'd1;
         else begin
            group_in = ((group_ff == 5'd0) ? width_ff : group_ff) - 5'd1;
            if (sum_bits < 6'(width_ff)) begin
               buf_in = merged; bits_in = 5'(sum_bits);
            end else begin
               buf_in  = merged >> width_ff;
               bits_in = 5'(sum_bits - 6'(width_ff));
               if (phase_ff == PH_FIRST) begin
                  if (fcode > 16'd255) begin
                     phase_in = PH_BADCODE; ostat_in = 4'(PH_BADCODE) - 4'd1;
                  end else begin
                     first_in = fcode[7:0]; prev_in = fcode;
                     push_en = 1'b1; push_val = fcode[7:0];
                     count_in = count_ff + 1'b1; phase_in = PH_CODES;
                  end
               end else if (fcode == CLEAR_CODE && block_ff) begin
                  skip_in = group_in; group_in = 5'd0; buf_in = '0; bits_in = '0;
                  width_in = 5'd9; last_in = 16'd255;
               end else if (fcode > last_ff) begin
                  if (fcode != last_p1 || prev_ff > last_ff) begin
                     phase_in = PH_BADCODE; ostat_in = 4'(PH_BADCODE) - 4'd1;
                  end else begin
                     push_en = 1'b1; push_val = first_ff;
                     count_in = count_ff + 1'b1;
                     code_in = fcode; cur_in = prev_ff; ready_in = 1'b1;
                  end
               end else begin
                  code_in = fcode; cur_in = fcode; ready_in = 1'b1;
               end
            end
         end
      end
      if (ctl.walk) begin
         if (cur_ff >= 16'd256) begin
            push_en = 1'b1; push_val = suf_rd_ff;
            count_in = count_ff + 1'b1;
            cur_in = 16'(pre_rd_ff);
         end else done_in = 1'b1;
      end
      if (ctl.push_head) begin
         push_en = 1'b1; push_val = cur_ff[7:0];
         count_in = count_ff + 1'b1;
         first_in = cur_ff[7:0];
         if (last_ff < mask) begin
            last_in = last_p1; tab_we = 1'b1;
         end
         prev_in = code_ff;
         if (last_in >= mask && width_ff < limit_ff) begin
            skip_in = group_ff; group_in = 5'd0; buf_in = '0; bits_in = '0;
            width_in = width_ff + 5'd1;
         end
      end
      if (ctl.finish) begin
         if (phase_ff < PH_DONE) begin
            if (phase_ff == PH_FLAGS || (skip_ff == 5'd0 && bits_ff >= 5'd8))
               phase_in = PH_TRUNC;
            else phase_in = PH_DONE;
         end
         ostat_in = 4'(phase_in) - 4'd1; obyte_in = 8'd0;
      end
      if (ctl.pull) begin
         if (count_ff == '0) begin
            ostat_in = ST_EMPTY; obyte_in = 8'd0;
         end else begin
            count_in = count_ff - 1'b1; ostat_in = ST_BYTE;
         end
      end
      if (ctl.take) begin
         obyte_in = 8'd0; ostat_in = ST_ACCEPT;
      end
   end

   logic pulled_ff;
   always_ff @(posedge clock) begin
      byte_ff <= ctl.take ? byte_i : byte_ff;
      code_ff <= code_in; cur_ff <= cur_in; first_ff <= first_in;
      obyte_ff <= obyte_in; ostat_ff <= ostat_in;
      pulled_ff <= ctl.take ? 1'b0 : (ctl.pull ? (count_ff != '0) : pulled_ff);
      if (reset) begin
         count_ff <= '0; phase_ff <= PH_FLAGS; width_ff <= 5'd9; limit_ff <= '0;
         block_ff <= 1'b0; last_ff <= '0; prev_ff <= '0; buf_ff <= '0;
         bits_ff <= '0; group_ff <= '0; skip_ff <= '0;
         ready_ff <= 1'b0; done_ff <= 1'b0; first_ff <= '0;
      end else begin
         count_ff <= count_in; phase_ff <= phase_in; width_ff <= width_in;
         limit_ff <= limit_in; block_ff <= block_in; last_ff <= last_in;
         prev_ff <= prev_in; buf_ff <= buf_in; bits_ff <= bits_in;
         group_ff <= group_in; skip_ff <= skip_in;
         ready_ff <= ready_in; done_ff <= done_in;
      end
   end

   assign stat.code_ready = ready_ff;
   assign stat.walk_done  = done_ff;
   assign out_byte_o = pulled_ff ? pop_byte_ff : obyte_ff;
   assign status_o   = ostat_ff;
   assign more_o     = count_ff != '0;
endmodule

@@ rtl/core/lzwd_ctrl.sv @@
// lzwd_ctrl: request sequencer and result handshake for the decoder
// depends on lzwd_pkg

module lzwd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lzwd_pkg::lzwd_cmd_type  ctl,
   input  lzwd_pkg::lzwd_stat_type stat
);
   import lzwd_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_SETTLE = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] cmd_ff;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.take = 1'b1; state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (cmd_ff)
               CMD_FEED: ctl.feed = 1'b1;
               CMD_END:  ctl.finish = 1'b1;
               CMD_PULL: ctl.pull = 1'b1;
               default: ;
            endcase
            state_in = (cmd_ff == CMD_FEED) ? S_CHECK : S_OUT;
         end
         S_CHECK: state_in = stat.code_ready ? S_WALK : S_OUT;
         S_WALK: begin
            ctl.walk = 1'b1; state_in = S_WAIT;
         end
         S_WAIT: begin
            if (stat.walk_done) begin
               ctl.push_head = 1'b1; state_in = S_OUT;
            end else state_in = S_SETTLE;
         end
         S_SETTLE: state_in = S_WALK;
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.take) cmd_ff <= req_cmd;
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl.feed, ctl.finish, ctl.pull, ctl.walk, ctl.push_head}) <= 1)
      else $error("overlapping datapath commands");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.take |=> state_ff == S_EXEC)
      else $error("request not executed");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while result pending");
endmodule

@@ dv/tb.sv @@
// tb: self-checking bench for lzw_compress_stream_decoder_core
// depends on lzwd_pkg and the decoder rtl; builds .Z code streams and predicts every response
`timescale 1ns / 100ps

module tb;
   import lzwd_pkg::*;

   typedef struct {
      logic [7:0] out_byte;
      logic [3:0] status;
      logic       more;
   } lzw_rsp_t;

   class lzw_scoreboard;
      logic [15:0] prefix_mem [65536];
      logic [7:0]  suffix_mem [65536];
      logic [7:0]  stack_mem [65536];
      int unsigned stack_count, phase, width, width_max, blk, last, prev, first;
      int unsigned bitbuf, bitcnt, grp_left, skip;
      int unsigned fails;
      lzw_rsp_t    expected_q [$];

      function void clear_state();
         stack_count = 0; phase = PH_FLAGS; width = 9; width_max = 0; blk = 0;
         last = 0; prev = 0; first = 0; bitbuf = 0; bitcnt = 0; grp_left = 0;
         skip = 0; fails = 0;
      endfunction

      function void push(int unsigned b);
         stack_mem[stack_count & 16'hffff] = b[7:0];
         if (stack_count < 65536) stack_count++;
      endfunction

      function void drop();
         skip = grp_left; grp_left = 0; bitbuf = 0; bitcnt = 0;
      endfunction

      function int unsigned decode_code(int unsigned code);
         int unsigned mask, cur;
         mask = (1 << width) - 1;
         cur = code;
         if (code == CLEAR_CODE && blk != 0) begin
            drop(); width = 9; last = 255;
            return ST_ACCEPT;
         end
         if (code > last) begin
            if (code != last + 1 || prev > last) begin
               phase = PH_BADCODE;
               return phase - 1;
            end
            push(first);
            cur = prev;
         end
         while (cur >= 256) begin
            push(suffix_mem[cur & 16'hffff]);
            cur = prefix_mem[cur & 16'hffff];
         end
         push(cur);
         first = cur & 8'hff;
         if (last < mask) begin
            last++;
            prefix_mem[last & 16'hffff] = prev[15:0];
            suffix_mem[last & 16'hffff] = first[7:0];
         end
         prev = code;
         if (last >= mask && width < width_max) begin
            drop(); width++;
         end
         return ST_ACCEPT;
      endfunction

      function int unsigned feed_byte(int unsigned b);
         int unsigned w, code;
         if (phase >= PH_DONE) return phase - 1;
         if (stack_count != 0) return ST_BUSY;
         if (phase == PH_FLAGS) begin
            w = b & 8'h1f;
            if ((b & 8'h60) != 0) begin phase = PH_BADFLAGS; return phase - 1; end
            if (w < 9 || w > 16) begin phase = PH_BADWIDTH; return phase - 1; end
            if (w == 9) w = 10;
            width_max = w; blk = (b >> 7) & 1; width = 9;
            last = blk ? 256 : 255;
            phase = PH_FIRST;
            return ST_ACCEPT;
         end
         if (skip != 0) begin skip--; return ST_ACCEPT; end
         if (grp_left == 0) grp_left = width;
         grp_left--;
         bitbuf = (bitbuf | (b << bitcnt)) & 24'hffffff;
         bitcnt += 8;
         if (bitcnt < width) return ST_ACCEPT;
         code = bitbuf & ((1 << width) - 1);
         bitbuf = bitbuf >> width;
         bitcnt -= width;
         if (phase == PH_FIRST) begin
            if (code > 255) begin phase = PH_BADCODE; return phase - 1; end
            first = code; prev = code; push(code); phase = PH_CODES;
            return ST_ACCEPT;
         end
         return decode_code(code);
      endfunction

      function void note_request(logic [1:0] cmd, logic [7:0] b);
         lzw_rsp_t r;
         r.out_byte = 8'd0;
         r.status = ST_ACCEPT;
         case (cmd)
            CMD_FEED: r.status = 4'(feed_byte(b));
            CMD_END: begin
               if (phase < PH_DONE) begin
                  if (phase == PH_FLAGS) phase = PH_TRUNC;
                  else if (skip == 0 && bitcnt >= 8) phase = PH_TRUNC;
                  else phase = PH_DONE;
               end
               r.status = 4'(phase - 1);
            end
            CMD_PULL: begin
               if (stack_count == 0) r.status = ST_EMPTY;
               else begin
                  stack_count--;
                  r.out_byte = stack_mem[stack_count & 16'hffff];
                  r.status = ST_BYTE;
               end
            end
            default: ;
         endcase
         r.more = stack_count != 0;
         expected_q.push_back(r);
      endfunction

      function void check_response(logic [7:0] ob, logic [3:0] st, logic mp);
         lzw_rsp_t e;
         if (expected_q.size() == 0) begin
            $error("response with no request waiting");
            fails++;
            return;
         end
         e = expected_q.pop_front();
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st); fails++;
         end
         if (ob !== e.out_byte) begin
            $error("out_byte expected %0h actual %0h", e.out_byte, ob); fails++;
         end
         if (mp !== e.more) begin
            $error("more_pending expected %0d actual %0d", e.more, mp); fails++;
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_cmd = 0;
   logic [7:0] req_in_byte = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic [7:0] rsp_out_byte;
   logic [3:0] rsp_status;
   logic       rsp_more_pending;

   lzw_scoreboard sb = new();
   int unsigned   req_count = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   burst_left = 0;
   int unsigned   hold_left = 0;
   bit            hold_done = 0;
   bit            pause_done = 0;
   int unsigned   stall_mode = 0;

   // encoder side of the stream
   int unsigned enc_acc, enc_nacc, enc_grp, enc_w, enc_last, enc_prev, enc_limit, enc_blk;

   lzw_compress_stream_decoder_core dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_out_byte, rsp_status, rsp_more_pending);
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else if (!hold_done && req_count >= 60) begin
         hold_done = 1;
         hold_left = 400;
         rsp_ready <= 0;
      end else begin
         if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 3) != 0;
            2: rsp_ready <= $urandom_range(0, 1) != 0;
            default: rsp_ready <= $urandom_range(0, 7) == 0;
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send(logic [1:0] cmd, logic [7:0] b);
      int unsigned gap;
      if (!pause_done && req_count >= 150) begin
         pause_done = 1;
         req_valid <= 0;
         do @(posedge clock); while (sb.expected_q.size() != 0);
      end
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1;
      req_cmd <= cmd;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, b);
      req_count++;
   endtask

   task automatic put_byte(logic [7:0] b);
      while (sb.stack_count != 0) begin
         if ($urandom_range(0, 19) == 0) send(CMD_FEED, 8'($urandom_range(0, 255)));
         send(CMD_PULL, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 29) == 0) send(CMD_NOP, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 29) == 0) send(CMD_PULL, 8'($urandom_range(0, 255)));
      send(CMD_FEED, b);
   endtask

   task automatic enc_out(logic [7:0] b);
      put_byte(b);
      enc_grp++;
      if (enc_grp == enc_w) enc_grp = 0;
   endtask

   task automatic enc_drop();
      if (enc_nacc > 0) enc_out(8'(enc_acc));
      if (enc_grp > 0) repeat (enc_w - enc_grp) put_byte(8'($urandom_range(0, 255)));
      enc_grp = 0; enc_acc = 0; enc_nacc = 0;
   endtask

   task automatic enc_code(int unsigned c, bit first_code);
      int unsigned mask;
      mask = (1 << enc_w) - 1;
      enc_acc = enc_acc | (c << enc_nacc);
      enc_nacc += enc_w;
      while (enc_nacc >= 8) begin
         enc_out(8'(enc_acc));
         enc_acc = enc_acc >> 8;
         enc_nacc -= 8;
      end
      if (first_code) enc_prev = c;
      else if (c == CLEAR_CODE && enc_blk != 0) begin
         enc_drop(); enc_w = 9; enc_last = 255;
      end else begin
         if (enc_last < mask) enc_last++;
         enc_prev = c;
         if (enc_last >= mask && enc_w < enc_limit) begin
            enc_drop(); enc_w++;
         end
      end
   endtask

   function automatic int unsigned pick_code();
      int unsigned c, mask;
      mask = (1 << enc_w) - 1;
      c = $urandom_range(0, enc_last + 1);
      if (enc_blk != 0 && c == CLEAR_CODE && $urandom_range(0, 49) != 0)
         c = $urandom_range(0, 255);
      if (c == enc_last + 1 && (enc_prev > enc_last || c > mask)) c = $urandom_range(0, 255);
      return c;
   endfunction

   initial begin
      int unsigned scenario, ending, ncodes, w;
      sb.clear_state();
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send(CMD_PULL, 8'h00);
      send(CMD_NOP, 8'hff);
      send(CMD_NOP, 8'h00);
      scenario = $urandom_range(0, 11);
      if (scenario == 0)
         put_byte(8'({1'b1, 2'b11, 5'd16} ^ ($urandom_range(0, 1) << 5)));
      else if (scenario == 1) begin
         w = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(17, 31);
         put_byte({1'($urandom_range(0, 1)), 2'b00, w[4:0]});
      end else begin
         enc_limit = $urandom_range(9, 16);
         enc_blk = $urandom_range(0, 1);
         put_byte({enc_blk[0], 2'b00, enc_limit[4:0]});
         if (enc_limit == 9) enc_limit = 10;
         enc_w = 9; enc_last = enc_blk ? 256 : 255;
         enc_acc = 0; enc_nacc = 0; enc_grp = 0;
         ending = $urandom_range(0, 5);
         if (ending == 0 && $urandom_range(0, 1)) enc_code($urandom_range(256, 511), 1);
         else begin
            enc_code($urandom_range(0, 1) ? 255 : $urandom_range(0, 255), 1);
            enc_code(enc_last + 1, 0);
            ncodes = $urandom_range(0, 2) == 0 ? 270 : $urandom_range(20, 120);
            repeat (ncodes) enc_code(pick_code(), 0);
            if (ending == 1 && enc_last + 2 <= (1 << enc_w) - 1) enc_code(enc_last + 2, 0);
            if (ending == 2 || ending == 3) begin
               if (enc_nacc > 0) enc_out(8'(enc_acc));
               repeat ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      if ($urandom_range(0, 1)) send(CMD_END, 8'($urandom_range(0, 255)));
      else put_byte(8'($urandom_range(0, 255)));
      send(CMD_END, 8'($urandom_range(0, 255)));
      repeat (4) send(CMD_FEED, 8'($urandom_range(0, 255)));
      while (req_count < 380) send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      while (sb.stack_count != 0) send(CMD_PULL, 8'($urandom_range(0, 255)));
      send(CMD_PULL, 8'hff);
      send(CMD_END, 8'h00);
      req_valid <= 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.fails == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule

@@ lzw_compress_stream_decoder_core.f @@
rtl/core/lzwd_pkg.sv
rtl/core/lzwd_datapath.sv
rtl/core/lzwd_ctrl.sv
rtl/core/lzw_compress_stream_decoder_core.sv
dv/tb.sv
